@@ rtl/core/olad_pkg.sv @@
package olad_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned StatusW      = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LIST   = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_APPENDED  = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_DELETED   = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_ENTRY     = 3'd4,
    STATUS_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

endpackage

@@ rtl/core/olad_cell.sv @@
module olad_cell (
  input  logic                           clk_i,
  input  olad_pkg::cell_ctrl_t           ctrl_i,
  input  logic [olad_pkg::DataW-1:0]     wr_data_i,
  input  logic [olad_pkg::DataW-1:0]     nbr_data_i,
  output logic [olad_pkg::DataW-1:0]     data_o
);

  logic [olad_pkg::DataW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      data_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= nbr_data_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/ordered_list_append_delete_top.sv @@
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells, head in the
// first cell. An append, a delete or list on an empty list, and an unused mode need no walk
// and give at most one transaction on the output. A delete or a list on a list of N
// entries walks the chain: every cycle the head leaves the first cell, all cells move one
// place toward the head, and the old head is written back behind the last entry (a deleted
// match is not written back). The walk takes N steps, N being at most DEPTH, and each step
// waits while the output register holds a transaction that has not been taken. A new input
// transaction is accepted once the walk is over and the output register is free.
module ordered_list_append_delete_top #(
  parameter int unsigned DEPTH = olad_pkg::DefaultDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // value[31:0]
  input  logic [olad_pkg::DataW-1:0]     s_axis_tdata_i,
  // mode[1:0]
  input  logic [olad_pkg::ModeW-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // entry_value[31:0]
  output logic [olad_pkg::DataW-1:0]     m_axis_tdata_o,
  // status[2:0]
  output logic [olad_pkg::StatusW-1:0]   m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  olad_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  step_q, step_d;
  logic [CntW-1:0]  len_q, len_d;
  logic             found_q, found_d;
  logic             is_list_q, is_list_d;
  logic [olad_pkg::DataW-1:0] value_q, value_d;

  logic                          m_valid_q;
  logic [olad_pkg::DataW-1:0]    m_data_q;
  olad_pkg::status_e             m_status_q;
  logic                          m_last_q;

  logic                          ld;
  olad_pkg::status_e             ld_status;
  logic [olad_pkg::DataW-1:0]    ld_data;
  logic                          ld_last;

  logic                          out_free;
  logic                          in_acc;
  logic                          shift;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_idx;
  logic [olad_pkg::DataW-1:0]    wr_data;
  logic [CntW-1:0]               len_m1;
  logic [CntW-1:0]               step_p1;
  logic                          match;
  logic                          last_step;

  logic [olad_pkg::DataW-1:0]    cell_data [DEPTH];
  olad_pkg::cell_ctrl_t          cell_ctrl [DEPTH];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == olad_pkg::ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign len_m1          = len_q - CntW'(1);
  assign step_p1         = step_q + CntW'(1);
  assign last_step       = (step_p1 == count_q);
  assign match           = !is_list_q && !found_q && (cell_data[0] == value_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    len_d     = len_q;
    found_d   = found_q;
    is_list_d = is_list_q;
    value_d   = value_q;
    ld        = 1'b0;
    ld_status = olad_pkg::STATUS_APPENDED;
    ld_data   = s_axis_tdata_i;
    ld_last   = 1'b1;
    shift     = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = count_q[IdxW-1:0];
    wr_data   = s_axis_tdata_i;
    case (state_q)
      olad_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser_i)
            olad_pkg::MODE_APPEND: begin
              ld = 1'b1;
              if (count_q == CntW'(DEPTH)) begin
                ld_status = olad_pkg::STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            olad_pkg::MODE_DELETE: begin
              if (count_q == '0) begin
                ld        = 1'b1;
                ld_status = olad_pkg::STATUS_NOT_FOUND;
              end else begin
                state_d   = olad_pkg::ST_WALK;
                step_d    = '0;
                len_d     = count_q;
                found_d   = 1'b0;
                is_list_d = 1'b0;
                value_d   = s_axis_tdata_i;
              end
            end
            olad_pkg::MODE_LIST: begin
              if (count_q == '0) begin
                ld        = 1'b1;
                ld_status = olad_pkg::STATUS_EMPTY;
                ld_data   = '0;
              end else begin
                state_d   = olad_pkg::ST_WALK;
                step_d    = '0;
                len_d     = count_q;
                found_d   = 1'b0;
                is_list_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      olad_pkg::ST_WALK: begin
        if (out_free) begin
          shift   = 1'b1;
          wr_idx  = len_m1[IdxW-1:0];
          wr_data = cell_data[0];
          step_d  = step_p1;
          if (match) begin
            found_d = 1'b1;
            len_d   = len_m1;
          end else begin
            wr_en = 1'b1;
          end
          if (is_list_q) begin
            ld        = 1'b1;
            ld_status = olad_pkg::STATUS_ENTRY;
            ld_data   = cell_data[0];
            ld_last   = last_step;
          end else if (last_step) begin
            ld        = 1'b1;
            ld_status = (found_q || match) ? olad_pkg::STATUS_DELETED
                                           : olad_pkg::STATUS_NOT_FOUND;
            ld_data   = value_q;
          end
          if (last_step) begin
            state_d = olad_pkg::ST_IDLE;
            count_d = match ? len_m1 : len_q;
          end
        end
      end
      default: begin
        state_d = olad_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= olad_pkg::ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (ld) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    len_q     <= len_d;
    found_q   <= found_d;
    is_list_q <= is_list_d;
    value_q   <= value_d;
    if (ld) begin
      m_status_q <= ld_status;
      m_data_q   <= ld_data;
      m_last_q   <= ld_last;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [olad_pkg::DataW-1:0] nbr_data;

    if (i == DEPTH - 1) begin : g_tail
      assign nbr_data = cell_data[i];
    end else begin : g_body
      assign nbr_data = cell_data[i+1];
    end

    assign cell_ctrl[i].shift = shift;
    assign cell_ctrl[i].write = wr_en && (wr_idx == IdxW'(i));

    olad_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .wr_data_i  (wr_data),
      .nbr_data_i (nbr_data),
      .data_o     (cell_data[i])
    );
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

@@ bench/olad_checker.sv @@
module olad_checker
  import olad_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [DataW-1:0]     in_value_i,
  input  logic [ModeW-1:0]     in_mode_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DataW-1:0]     out_value_i,
  input  logic [StatusW-1:0]   out_status_i,
  input  logic                 out_last_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o,
  output int unsigned          checked_o,
  output int unsigned          full_drops_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] value;
    logic                    last;
  } list_result_t;

  logic signed [DataW-1:0] shadow_entries [DEPTH];
  int unsigned             shadow_count;
  list_result_t            awaited_results [$];

  task automatic await_result(input status_e status, input logic [DataW-1:0] value,
                              input logic last);
    list_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    awaited_results.push_back(r);
    if (status == STATUS_FULL) begin
      full_drops_o++;
    end
  endtask

  task automatic apply_operation(input logic [ModeW-1:0] mode, input logic [DataW-1:0] value);
    int found;
    found = -1;
    case (mode)
      MODE_APPEND: begin
        if (shadow_count >= DEPTH) begin
          await_result(STATUS_FULL, value, 1'b1);
        end else begin
          shadow_entries[shadow_count] = value;
          shadow_count++;
          await_result(STATUS_APPENDED, value, 1'b1);
        end
      end
      MODE_DELETE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (found < 0 && shadow_entries[i] == value) begin
            found = i;
          end
        end
        if (found < 0) begin
          await_result(STATUS_NOT_FOUND, value, 1'b1);
        end else begin
          for (int j = found; j + 1 < shadow_count; j++) begin
            shadow_entries[j] = shadow_entries[j+1];
          end
          shadow_count--;
          await_result(STATUS_DELETED, value, 1'b1);
        end
      end
      MODE_LIST: begin
        if (shadow_count == 0) begin
          await_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            await_result(STATUS_ENTRY, shadow_entries[i], (i + 1 == shadow_count));
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    list_result_t want;
    if (!rst_ni) begin
      shadow_count     = 0;
      awaited_results.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
      checked_o        = 0;
      full_drops_o     = 0;
    end else begin
      // Results are checked before the new item is predicted, since a result
      // leaving at this edge always belongs to an earlier transaction.
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (awaited_results.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected result status %0d value %h last %b", $realtime,
                     out_status_i, out_value_i, out_last_i);
          end
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status_i !== want.status || out_value_i !== want.value ||
              out_last_i !== want.last) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: expected status %s value %h last %b, got status %0d value %h last %b",
                       $realtime, want.status.name(), want.value, want.last,
                       out_status_i, out_value_i, out_last_i);
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_operation(in_mode_i, in_value_i);
      end
      outstanding_o = awaited_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import olad_pkg::*;

  localparam int unsigned Depth       = DefaultDepth;
  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 90;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                s_valid;
  logic                s_ready;
  logic [DataW-1:0]    s_data;
  logic [ModeW-1:0]    s_user;
  logic                m_valid;
  logic                m_ready;
  logic [DataW-1:0]    m_data;
  logic [StatusW-1:0]  m_user;
  logic                m_last;

  int unsigned         mismatches;
  int unsigned         outstanding;
  int unsigned         checked;
  int unsigned         full_drops;
  int unsigned         cycle_cnt;
  int unsigned         src_idle;
  int unsigned         snk_idle;
  int unsigned         op_count [4];
  bit                  hold_req;
  logic [DataW-1:0]    value_pool [$];

  ordered_list_append_delete_top #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  olad_checker #(
    .DEPTH(Depth)
  ) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (s_valid),
    .in_ready_i       (s_ready),
    .in_value_i       (s_data),
    .in_mode_i        (s_user),
    .out_valid_i      (m_valid),
    .out_ready_i      (m_ready),
    .out_value_i      (m_data),
    .out_status_i     (m_user),
    .out_last_i       (m_last),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .full_drops_o     (full_drops)
  );

  always begin
    clk = 1'b1;
    #(ClkPeriod / 2);
    clk = 1'b0;
    #(ClkPeriod / 2);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL ordered_list_append_delete_top");
    $finish;
  end

  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      m_ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [DataW-1:0] value);
    while ($urandom_range(0, 99) < src_idle) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= value;
    do @(posedge clk); while (!s_ready);
    op_count[mode]++;
    @(negedge clk);
  endtask

  task automatic send_random_op(input bit filling, output bit counted);
    int unsigned      pick;
    int unsigned      idx;
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      mode = ModeUnused;
    end else if (pick < 22) begin
      mode = MODE_LIST;
    end else if (pick < (filling ? 82 : 42)) begin
      mode = MODE_APPEND;
    end else begin
      mode = MODE_DELETE;
    end
    case ($urandom_range(0, 2))
      0: value = $urandom();
      1: value = DataW'($urandom_range(0, 15)) - DataW'(8);
      default: begin
        case ($urandom_range(0, 3))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = '0;
          default: value = '1;
        endcase
      end
    endcase
    if (mode == MODE_DELETE && value_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
      idx   = $urandom_range(0, value_pool.size() - 1);
      value = value_pool[idx];
      value_pool.delete(idx);
    end else if (mode == MODE_APPEND) begin
      value_pool.push_back(value);
      if (value_pool.size() > 40) begin
        void'(value_pool.pop_front());
      end
    end
    send_item(mode, value);
    counted = (mode != ModeUnused);
  endtask

  task automatic run_phase(input int unsigned items);
    int unsigned done;
    bit          filling;
    bit          counted;
    done    = 0;
    filling = 1'b1;
    while (done < items) begin
      if ($urandom_range(0, 19) == 0) begin
        filling = !filling;
      end
      send_random_op(filling, counted);
      if (counted) begin
        done++;
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    s_valid  = 1'b0;
    s_data   = '0;
    s_user   = MODE_APPEND;
    hold_req = 1'b0;
    src_idle = 31;
    snk_idle = 70;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(MODE_LIST, 32'h0000_0000);
    send_item(MODE_DELETE, 32'h1234_5678);
    send_item(ModeUnused, $urandom());
    send_item(MODE_APPEND, 32'h8000_0000);
    send_item(MODE_DELETE, 32'h8000_0000);
    send_item(MODE_LIST, 32'hffff_ffff);
    send_item(MODE_APPEND, 32'h7fff_ffff);
    send_item(MODE_APPEND, 32'hffff_ffff);
    send_item(MODE_DELETE, 32'h7fff_ffff);
    send_item(MODE_APPEND, 32'h0000_0007);
    send_item(MODE_APPEND, 32'h0000_0007);
    send_item(MODE_DELETE, 32'h0000_0007);
    send_item(MODE_DELETE, 32'hffff_fffe);
    send_item(MODE_LIST, 32'h5555_aaaa);

    // The receiver stalls, which holds back the appends that keep coming; the list fills and
    // the last append is dropped.
    src_idle = 0;
    hold_req = 1'b1;
    repeat (15) send_item(MODE_APPEND, $urandom());
    send_item(MODE_LIST, 32'h0000_0000);

    src_idle = 31;
    snk_idle = 70;
    run_phase(PhaseItems);
    src_idle = 70;
    snk_idle = 31;
    run_phase(PhaseItems);
    src_idle = 0;
    snk_idle = 0;
    run_phase(PhaseItems);
    s_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (Depth + 4) @(negedge clk);

    $display("Sent %0d appends, %0d deletes, %0d lists and %0d unused-mode items.",
             op_count[MODE_APPEND], op_count[MODE_DELETE], op_count[MODE_LIST],
             op_count[ModeUnused]);
    $display("Checked %0d results, %0d of them appends dropped on a full list.",
             checked, full_drops);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS ordered_list_append_delete_top");
    end else begin
      $display("FAIL ordered_list_append_delete_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/olad_pkg.sv
rtl/core/olad_cell.sv
rtl/core/ordered_list_append_delete_top.sv
bench/olad_checker.sv
bench/tb_top.sv
